>>> hdl/wpc_pkg.sv
// Package: shared types, constants and register indexes of the wave phase colormap.
`timescale 1ns / 1ps

package wpc_pkg;

    // default magnitude precision of the sine, Q1.(SINE_BITS-1)
    localparam int SINE_BITS_DEF = 16;

    // pi/2 in Q1.30 and 1.0 in Q1.30
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    // Horner divisors of the sine series, innermost term first
    localparam int SERIES_TERMS = 6;
    localparam int unsigned SERIES_DIV [SERIES_TERMS] = '{156, 110, 72, 42, 20, 6};

    localparam logic [15:0] GAIN_RESET = 16'd256;
    localparam logic [7:0]  GRAY_MAX   = 8'd255;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INTENSITY_MODE = 3'd0,
        CFG_PHASE_OFFSET   = 3'd1,
        CFG_GAIN           = 3'd2,
        CFG_POSITIVE_COLOR = 3'd3,
        CFG_NEGATIVE_COLOR = 3'd4,
        CFG_ZERO_COLOR     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic        intensity_mode;
        logic [15:0] phase_offset;
        logic [15:0] gain;
        logic [23:0] positive_color;
        logic [23:0] negative_color;
        logic [23:0] zero_color;
    } t_cfg;

    // per-pixel data riding along the sine pipeline
    typedef struct packed {
        logic [15:0] amp;
        logic        neg;
        logic        last;
    } t_side;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pix;

endpackage

>>> hdl/wave_phase_colormap_unit.sv
// Top level: configuration registers, sine and color pipelines, output register with skid.
`timescale 1ns / 1ps

// Wave phase colormap. Takes one pixel (amplitude Q4.12, phase as a 16-bit binary
// angle, frame_end) per transaction and returns one RGB pixel per transaction, in
// order, with frame_end copied to o_last_pixel. Wave mode blends the zero color
// toward the positive or negative color by |amplitude * sin(phase - offset) * gain|
// clamped to 1.0; intensity mode gives gray = min(amplitude^2 * gain, 1) * 255.
// Throughput is one pixel per clock while o_in_stall is low. The sine series has
// six Horner steps of three stages each (multiply, reciprocal multiply, quotient
// correction) plus fold, argument and rounding stages; five color stages and the
// output register follow it. The pipeline moves on a single enable; a result that
// meets a stalled output goes into a skid register, and o_in_stall is that skid
// register's valid bit, so the input keeps taking pixels while one finished pixel
// waits. Configuration writes take effect on the next clock and must only be
// issued while no pixel is in flight.
module wave_phase_colormap_unit #(
    parameter int SINE_BITS = wpc_pkg::SINE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [15:0]                     i_amplitude,
    input  logic [15:0]                     i_phase,
    input  logic                            i_frame_end,
    // pixel output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_red,
    output logic [7:0]                      o_green,
    output logic [7:0]                      o_blue,
    output logic                            o_last_pixel,
    // configuration writes
    input  logic                            i_cfg_wr_en,
    input  logic [wpc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [wpc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    wpc_pkg::t_cfg        r_cfg;

    logic                 w_en;         // pipeline advance
    logic                 w_out_free;   // output register can take a pixel

    logic                 w_sine_valid;
    wpc_pkg::t_side       w_sine_side;
    logic [SINE_BITS-1:0] w_sine_s;

    logic                 w_tail_valid;
    wpc_pkg::t_pix        w_tail_pix;

    logic                 r_out_valid, n_out_valid;
    wpc_pkg::t_pix        r_out, n_out;
    logic                 r_skid_valid, n_skid_valid;
    wpc_pkg::t_pix        r_skid, n_skid;

    // ------------------------------------------------------------------
    // Configuration registers; writes past the last index are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.intensity_mode <= 1'b0;
            r_cfg.phase_offset   <= '0;
            r_cfg.gain           <= wpc_pkg::GAIN_RESET;
            r_cfg.positive_color <= '0;
            r_cfg.negative_color <= '0;
            r_cfg.zero_color     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (wpc_pkg::t_cfg_idx'(i_cfg_index))
                wpc_pkg::CFG_INTENSITY_MODE: r_cfg.intensity_mode <= i_cfg_data[0];
                wpc_pkg::CFG_PHASE_OFFSET:   r_cfg.phase_offset   <= i_cfg_data[15:0];
                wpc_pkg::CFG_GAIN:           r_cfg.gain           <= i_cfg_data[15:0];
                wpc_pkg::CFG_POSITIVE_COLOR: r_cfg.positive_color <= i_cfg_data;
                wpc_pkg::CFG_NEGATIVE_COLOR: r_cfg.negative_color <= i_cfg_data;
                wpc_pkg::CFG_ZERO_COLOR:     r_cfg.zero_color     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath: the whole pipeline holds only while the skid is occupied
    // ------------------------------------------------------------------
    assign w_en       = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    wpc_sine #(
        .SINE_BITS (SINE_BITS)
    ) u_sine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in_valid),
        .i_amp    (i_amplitude),
        .i_phase  (i_phase),
        .i_last   (i_frame_end),
        .i_offset (r_cfg.phase_offset),
        .o_valid  (w_sine_valid),
        .o_side   (w_sine_side),
        .o_s      (w_sine_s)
    );

    wpc_blend #(
        .SINE_BITS (SINE_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sine_valid),
        .i_side  (w_sine_side),
        .i_s     (w_sine_s),
        .i_cfg   (r_cfg),
        .o_valid (w_tail_valid),
        .o_pix   (w_tail_pix)
    );

    // ------------------------------------------------------------------
    // Output register plus skid. With the skid empty the pipeline tail
    // always has a home: the output register if it frees up this cycle,
    // otherwise the skid.
    // ------------------------------------------------------------------
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_out_free) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (w_out_free) begin
            n_out_valid = w_tail_valid;
            n_out       = w_tail_pix;
        end else if (w_tail_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = w_tail_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid  = r_out_valid;
    assign o_red        = r_out.red;
    assign o_green      = r_out.green;
    assign o_blue       = r_out.blue;
    assign o_last_pixel = r_out.last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // a parked pixel always has one ahead of it in the output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a pixel while output register is empty");

    // the skid only fills when the output is held
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skid_valid && n_skid_valid) |-> (r_out_valid && i_out_stall))
        else $error("skid filled without output backpressure");

    // while the output stays stalled, the parked pixel is kept
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> (r_skid_valid && $stable(r_skid)))
        else $error("parked pixel lost under stall");

endmodule

>>> hdl/wpc_series_term.sv
// One Horner step of the sine series: t' = 1 - ((x2 * t) >> 30) / DIV, three stages.
`timescale 1ns / 1ps

module wpc_series_term #(
    parameter int unsigned DIV = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  wpc_pkg::t_side       i_side,
    input  logic [30:0]          i_x,
    input  logic [31:0]          i_x2,
    input  logic [30:0]          i_t,
    output logic                 o_valid,
    output wpc_pkg::t_side       o_side,
    output logic [30:0]          o_x,
    output logic [31:0]          o_x2,
    output logic [30:0]          o_t
);

    // floor(2^32 / DIV); quotient estimate is low by at most one
    localparam logic [63:0] RECIP_FULL = (64'd1 << 32) / DIV;
    localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
    localparam logic [31:0] DIV_W      = 32'(DIV);

    logic                 r_a_valid, r_b_valid, r_c_valid;
    wpc_pkg::t_side       r_a_side, r_b_side, r_c_side;
    logic [30:0]          r_a_x, r_b_x, r_c_x;
    logic [31:0]          r_a_x2, r_b_x2, r_c_x2;
    logic [31:0]          r_a_p, r_b_p;
    logic [31:0]          r_b_q0;
    logic [30:0]          r_c_t;

    logic [62:0]          w_pa;
    logic [63:0]          w_pb;
    logic [31:0]          w_rem;
    logic [31:0]          w_q;

    assign w_pa  = 63'(i_x2) * 63'(i_t);
    assign w_pb  = 64'(r_a_p) * 64'(RECIP);
    assign w_rem = r_b_p - r_b_q0 * DIV_W;
    assign w_q   = (w_rem >= DIV_W) ? r_b_q0 + 32'd1 : r_b_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side <= i_side;
            r_a_x    <= i_x;
            r_a_x2   <= i_x2;
            r_a_p    <= w_pa[61:30];

            r_b_side <= r_a_side;
            r_b_x    <= r_a_x;
            r_b_x2   <= r_a_x2;
            r_b_p    <= r_a_p;
            r_b_q0   <= w_pb[63:32];

            r_c_side <= r_b_side;
            r_c_x    <= r_b_x;
            r_c_x2   <= r_b_x2;
            r_c_t    <= wpc_pkg::ONE_Q30 - w_q[30:0];
        end
    end

    assign o_valid = r_c_valid;
    assign o_side  = r_c_side;
    assign o_x     = r_c_x;
    assign o_x2    = r_c_x2;
    assign o_t     = r_c_t;

    // the series partial stays in (0, 1.0]; a bad quotient correction breaks this
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_t <= wpc_pkg::ONE_Q30) && (o_t != '0)))
        else $error("series term out of range");

endmodule

>>> hdl/wpc_sine.sv
// Sine magnitude pipeline: angle fold, Q1.30 argument, Horner series, rounding.
`timescale 1ns / 1ps

module wpc_sine #(
    parameter int SINE_BITS = wpc_pkg::SINE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [15:0]          i_amp,
    input  logic [15:0]          i_phase,
    input  logic                 i_last,
    input  logic [15:0]          i_offset,
    output logic                 o_valid,
    output wpc_pkg::t_side       o_side,
    output logic [SINE_BITS-1:0] o_s
);

    localparam int NT = wpc_pkg::SERIES_TERMS;
    localparam logic [31:0]          RND   = 32'd1 << (30 - SINE_BITS);
    localparam logic [SINE_BITS-1:0] S_MAX = SINE_BITS'(1) << (SINE_BITS - 1);

    logic [15:0]          w_ang;
    logic [14:0]          w_r;
    wpc_pkg::t_side       w_side;
    logic [45:0]          w_xp;
    logic [61:0]          w_x2p;
    logic [61:0]          w_sp;
    logic [31:0]          w_rnd;

    logic                 r_s0_valid, r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    wpc_pkg::t_side       r_s0_side, r_s1_side, r_s2_side, r_s3_side, r_s4_side;
    logic [14:0]          r_s0_r;
    logic [30:0]          r_s1_x, r_s2_x;
    logic [31:0]          r_s2_x2;
    logic [31:0]          r_s3_s30;
    logic [SINE_BITS-1:0] r_s4_s;

    logic                 c_valid [NT+1];
    wpc_pkg::t_side       c_side  [NT+1];
    logic [30:0]          c_x     [NT+1];
    logic [31:0]          c_x2    [NT+1];
    logic [30:0]          c_t     [NT+1];

    // fold to a quarter wave: odd quadrants mirror, upper half negates
    assign w_ang = i_phase - i_offset;
    assign w_r   = w_ang[14] ? 15'(15'd16384 - {1'b0, w_ang[13:0]}) : {1'b0, w_ang[13:0]};
    assign w_side.amp  = i_amp;
    assign w_side.neg  = w_ang[15];
    assign w_side.last = i_last;

    assign w_xp  = 46'(r_s0_r) * 46'(wpc_pkg::HALF_PI_Q30);
    assign w_x2p = 62'(r_s1_x) * 62'(r_s1_x);

    assign c_valid[0] = r_s2_valid;
    assign c_side[0]  = r_s2_side;
    assign c_x[0]     = r_s2_x;
    assign c_x2[0]    = r_s2_x2;
    assign c_t[0]     = wpc_pkg::ONE_Q30;

    for (genvar k = 0; k < NT; k++) begin : g_term
        wpc_series_term #(
            .DIV (wpc_pkg::SERIES_DIV[k])
        ) u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (c_valid[k]),
            .i_side  (c_side[k]),
            .i_x     (c_x[k]),
            .i_x2    (c_x2[k]),
            .i_t     (c_t[k]),
            .o_valid (c_valid[k+1]),
            .o_side  (c_side[k+1]),
            .o_x     (c_x[k+1]),
            .o_x2    (c_x2[k+1]),
            .o_t     (c_t[k+1])
        );
    end

    assign w_sp  = 62'(c_x[NT]) * 62'(c_t[NT]);
    assign w_rnd = r_s3_s30 + RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= c_valid[NT];
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_side <= w_side;
            r_s0_r    <= w_r;
            r_s1_side <= r_s0_side;
            r_s1_x    <= w_xp[44:14];
            r_s2_side <= r_s1_side;
            r_s2_x    <= r_s1_x;
            r_s2_x2   <= w_x2p[61:30];
            r_s3_side <= c_side[NT];
            r_s3_s30  <= w_sp[61:30];
            r_s4_side <= r_s3_side;
            r_s4_s    <= w_rnd[30 -: SINE_BITS];
        end
    end

    assign o_valid = r_s4_valid;
    assign o_side  = r_s4_side;
    assign o_s     = r_s4_s;

    a_s_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid |-> (r_s4_s <= S_MAX))
        else $error("sine magnitude above 1.0");

endmodule

>>> hdl/wpc_blend.sv
// Color stages: amplitude*gain*sine, saturation, per-channel blend, intensity gray.
`timescale 1ns / 1ps

module wpc_blend #(
    parameter int SINE_BITS = wpc_pkg::SINE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  wpc_pkg::t_side       i_side,
    input  logic [SINE_BITS-1:0] i_s,
    input  wpc_pkg::t_cfg        i_cfg,
    output logic                 o_valid,
    output wpc_pkg::t_pix        o_pix
);

    localparam int FRAC = 19 + SINE_BITS;   // fraction bits of the blend weight
    localparam int MW   = 32 + SINE_BITS;
    localparam int SW   = FRAC + 1;
    localparam int PW   = SW + 9;
    localparam logic [MW-1:0] ONE_M = MW'(1) << FRAC;

    logic                 r_b0_valid, r_b1_valid, r_b2_valid, r_b3_valid, r_b4_valid;
    logic [31:0]          r_b0_ag, r_b0_aa;
    logic [SINE_BITS-1:0] r_b0_s;
    logic                 r_b0_neg, r_b1_neg;
    logic                 r_b0_last, r_b1_last, r_b2_last, r_b3_last;
    logic [MW-1:0]        r_b1_m;
    logic [47:0]          r_b1_q;
    logic [SW-1:0]        r_b2_m;
    logic [23:0]          r_b2_far;
    logic [7:0]           r_b2_gray, r_b3_gray;
    logic signed [PW-1:0] r_b3_prod [3];
    wpc_pkg::t_pix        r_b4_pix;

    logic [SW-1:0]        w_m_sat;
    logic [39:0]          w_gray_full;
    logic [7:0]           w_gray;
    logic signed [PW-1:0] w_prod [3];
    logic [7:0]           w_ch [3];
    wpc_pkg::t_pix        w_pix;

    // weight saturates at 1.0
    assign w_m_sat = (r_b1_m > ONE_M) ? ONE_M[SW-1:0] : r_b1_m[SW-1:0];

    // q * 255 >> 32 for q below 1.0
    assign w_gray_full = {r_b1_q[31:0], 8'b0} - {8'b0, r_b1_q[31:0]};
    assign w_gray      = (|r_b1_q[47:32]) ? wpc_pkg::GRAY_MAX : w_gray_full[39:32];

    // C*m + Z*(1-m) == Z*1 + (C-Z)*m, so a floor shift of (C-Z)*m plus Z is exact
    for (genvar c = 0; c < 3; c++) begin : g_ch
        localparam int SH = 16 - 8 * c;
        logic [8:0]           w_diff;
        logic signed [PW-1:0] w_sh;

        assign w_diff    = {1'b0, r_b2_far[SH +: 8]} - {1'b0, i_cfg.zero_color[SH +: 8]};
        assign w_prod[c] = $signed(w_diff) * $signed({1'b0, r_b2_m});
        assign w_sh      = r_b3_prod[c] >>> FRAC;
        assign w_ch[c]   = w_sh[7:0] + i_cfg.zero_color[SH +: 8];
    end

    always_comb begin
        w_pix.last = r_b3_last;
        if (i_cfg.intensity_mode) begin
            w_pix.red   = r_b3_gray;
            w_pix.green = r_b3_gray;
            w_pix.blue  = r_b3_gray;
        end else begin
            w_pix.red   = w_ch[0];
            w_pix.green = w_ch[1];
            w_pix.blue  = w_ch[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_valid <= 1'b0;
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
            r_b4_valid <= 1'b0;
        end else if (i_en) begin
            r_b0_valid <= i_valid;
            r_b1_valid <= r_b0_valid;
            r_b2_valid <= r_b1_valid;
            r_b3_valid <= r_b2_valid;
            r_b4_valid <= r_b3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b0_ag   <= 32'(i_side.amp) * 32'(i_cfg.gain);
            r_b0_aa   <= 32'(i_side.amp) * 32'(i_side.amp);
            r_b0_s    <= i_s;
            r_b0_neg  <= i_side.neg;
            r_b0_last <= i_side.last;

            r_b1_m    <= MW'(r_b0_ag) * MW'(r_b0_s);
            r_b1_q    <= 48'(r_b0_aa) * 48'(i_cfg.gain);
            r_b1_neg  <= r_b0_neg;
            r_b1_last <= r_b0_last;

            r_b2_m    <= w_m_sat;
            r_b2_far  <= r_b1_neg ? i_cfg.negative_color : i_cfg.positive_color;
            r_b2_gray <= w_gray;
            r_b2_last <= r_b1_last;

            r_b3_prod <= w_prod;
            r_b3_gray <= r_b2_gray;
            r_b3_last <= r_b2_last;

            r_b4_pix  <= w_pix;
        end
    end

    assign o_valid = r_b4_valid;
    assign o_pix   = r_b4_pix;

endmodule
